@@ rtl/core/glyph_row_pixel_blitter_assert.svh @@
// Assertion macros shared by the glyph row pixel blitter modules.
`ifndef GLYPH_ROW_PIXEL_BLITTER_ASSERT_SVH
`define GLYPH_ROW_PIXEL_BLITTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GRPB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GRPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/grpb_pkg.sv @@
// Shared types and constants of the glyph row pixel blitter.
package grpb_pkg;

	localparam int GLYPH_SIZE = 16;
	localparam int GLYPH_IDX_W = $clog2(GLYPH_SIZE);
	localparam int COORD_W = 12;
	localparam int PX_W = COORD_W + 1;
	localparam int BYTE_OFF_W = PX_W + 2;
	localparam int ADDR_W = 26;
	localparam int DATA_W = 24;
	localparam int DIM_IN_W = 13;
	localparam int QDEPTH = 4;

	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd3;

	localparam logic [DATA_W-1:0] MASK_HI_NIB = 24'h0000F0;
	localparam logic [DATA_W-1:0] MASK_LO_NIB = 24'h00000F;
	localparam logic [DATA_W-1:0] MASK_BYTE = 24'h0000FF;
	localparam logic [DATA_W-1:0] MASK_FULL = 24'hFFFFFF;
	localparam logic [7:0] BIT_MSB = 8'h80;

	typedef enum logic [1:0] {
		FMT_1BPP = 2'd0,
		FMT_4BPP = 2'd1,
		FMT_8BPP = 2'd2,
		FMT_24BPP = 2'd3
	} pix_fmt_t;

	typedef struct packed {
		pix_fmt_t fmt;
		logic [DIM_IN_W-1:0] width;
		logic [DIM_IN_W-1:0] height;
		logic [DATA_W-1:0] fg;
	} grpb_cfg_t;

	localparam pix_fmt_t RST_FMT = FMT_24BPP;
	localparam logic [DIM_IN_W-1:0] RST_WIDTH = 13'd1920;
	localparam logic [DIM_IN_W-1:0] RST_HEIGHT = 13'd1080;
	localparam logic [DATA_W-1:0] RST_FG = 24'd0;

	// One classified glyph row: row base address, origin x, in-image ink (bit j = column j).
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [COORD_W-1:0] gx;
		logic [GLYPH_SIZE-1:0] pix;
	} grpb_job_t;

endpackage

@@ rtl/core/grpb_front.sv @@
// Front end: accepts glyph rows, clips them to the image and computes the row base address.
`include "glyph_row_pixel_blitter_assert.svh"

module grpb_front import grpb_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,
	input  grpb_cfg_t cfg,
	input  logic push,
	output logic full,
	input  logic [GLYPH_SIZE-1:0] glyph_row_bits,
	input  logic [COORD_W-1:0] glyph_x,
	input  logic [COORD_W-1:0] glyph_y,
	input  logic [GLYPH_IDX_W-1:0] row_index,
	output logic job_valid,
	input  logic job_ready,
	output grpb_job_t job
);

	localparam int DW_W = $clog2(MAX_WIDTH + 1);
	localparam int HW_W = $clog2(MAX_HEIGHT + 1);
	localparam int BW_W = DW_W + 5;
	localparam int RB_W = DW_W + 3;
	localparam int PROD_W = HW_W + RB_W;

	logic s1_valid_q;
	logic [GLYPH_SIZE-1:0] bits_s1;
	logic [COORD_W-1:0] gx_s1;
	logic [COORD_W-1:0] gy_s1;
	logic [GLYPH_IDX_W-1:0] ri_s1;

	logic s2_valid_q;
	logic [HW_W-1:0] row_s2;
	logic [RB_W-1:0] rb_s2;
	logic [COORD_W-1:0] gx_s2;
	logic [GLYPH_SIZE-1:0] pix_s2;

	logic s1_go, s2_go;
	logic [DW_W-1:0] w_sat;
	logic [HW_W-1:0] h_sat;
	logic [PX_W-1:0] py;
	logic row_ok;
	logic [HW_W-1:0] row_c;
	logic [BW_W-1:0] bits_w;
	logic [BW_W:0] bits_rnd;
	logic [RB_W-1:0] rb_c;
	logic [GLYPH_SIZE-1:0] pix_c;
	logic [PROD_W-1:0] prod;

	assign s2_go = !s2_valid_q || job_ready;
	assign s1_go = !s1_valid_q || s2_go;
	assign full = !s1_go;

	always_comb begin
		w_sat = (cfg.width > MAX_WIDTH) ? DW_W'(MAX_WIDTH) : DW_W'(cfg.width);
		h_sat = (cfg.height > MAX_HEIGHT) ? HW_W'(MAX_HEIGHT) : HW_W'(cfg.height);
		py = PX_W'(gy_s1) + PX_W'(ri_s1);
		row_ok = (py != '0) && (py <= h_sat);
		row_c = HW_W'(h_sat - py);
		case (cfg.fmt)
			FMT_1BPP: bits_w = BW_W'(w_sat);
			FMT_4BPP: bits_w = BW_W'(w_sat) << 2;
			FMT_8BPP: bits_w = BW_W'(w_sat) << 3;
			FMT_24BPP: bits_w = (BW_W'(w_sat) << 4) + (BW_W'(w_sat) << 3);
			default: bits_w = BW_W'(w_sat);
		endcase
		// Round up to whole 32-bit words, then count bytes.
		bits_rnd = (BW_W + 1)'(bits_w) + (BW_W + 1)'(31);
		rb_c = {bits_rnd[BW_W:5], 2'b00};
		for (int j = 0; j < GLYPH_SIZE; j++) begin
			pix_c[j] = bits_s1[GLYPH_SIZE-1-j] &&
				((PX_W'(gx_s1) + PX_W'(j)) < w_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				s1_valid_q <= push;
			end
			if (s2_go) begin
				// Drop rows outside the image and rows with no visible ink.
				s2_valid_q <= s1_valid_q && row_ok && (pix_c != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && push) begin
			bits_s1 <= glyph_row_bits;
			gx_s1 <= glyph_x;
			gy_s1 <= glyph_y;
			ri_s1 <= row_index;
		end
		if (s2_go) begin
			row_s2 <= row_c;
			rb_s2 <= rb_c;
			gx_s2 <= gx_s1;
			pix_s2 <= pix_c;
		end
	end

	assign prod = PROD_W'(row_s2) * PROD_W'(rb_s2);

	assign job_valid = s2_valid_q;
	assign job.base = ADDR_W'(prod);
	assign job.gx = gx_s2;
	assign job.pix = pix_s2;

	`GRPB_ASSERT_NOW(a_front_no_empty_job, s2_valid_q, pix_s2 != '0, "front passed a row with no ink")

endmodule

@@ rtl/core/grpb_queue.sv @@
// Short job queue between the front end and the write generator.
`include "glyph_row_pixel_blitter_assert.svh"

module grpb_queue import grpb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  grpb_job_t wr_job,
	output logic rd_valid,
	input  logic rd_ready,
	output grpb_job_t rd_job
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	grpb_job_t mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic wr_fire, rd_fire;

	assign wr_ready = (count_q != CNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign wr_fire = wr_valid && wr_ready;
	assign rd_fire = rd_valid && rd_ready;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd_fire) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (wr_fire && !rd_fire) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (rd_fire && !wr_fire) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	`GRPB_ASSERT_NOW(a_queue_bound, 1'b1, count_q <= CNT_W'(QDEPTH), "queue count beyond depth")
	`GRPB_ASSERT_NEXT(a_queue_drain, rd_fire && !wr_fire, count_q == CNT_W'($past(count_q) - 1'b1), "queue count did not drop on read")

endmodule

@@ rtl/core/grpb_back.sv @@
// Write generator: one masked write per ink bit, left to right, each cycle pop allows.
`include "glyph_row_pixel_blitter_assert.svh"

module grpb_back import grpb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  grpb_cfg_t cfg,
	input  logic job_valid,
	output logic job_ready,
	input  grpb_job_t job,
	output logic empty,
	input  logic pop,
	output logic [ADDR_W-1:0] byte_address,
	output logic [DATA_W-1:0] write_data,
	output logic [DATA_W-1:0] write_mask,
	output logic last_write
);

	logic busy_q;
	grpb_job_t job_q;
	logic [GLYPH_SIZE-1:0] rem_q;
	logic ovalid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] mask_q;
	logic last_q;

	logic out_free, emit, last_c, load;
	logic [GLYPH_SIZE-1:0] pick, rest;
	logic [GLYPH_IDX_W-1:0] idx;
	logic [PX_W-1:0] px;
	logic [BYTE_OFF_W-1:0] boff;
	logic [DATA_W-1:0] data_c, mask_c;

	assign out_free = !ovalid_q || pop;
	assign emit = busy_q && out_free;
	assign pick = rem_q & (~rem_q + 1'b1);
	assign rest = rem_q & ~pick;
	assign last_c = (rest == '0);
	assign job_ready = !busy_q || (emit && last_c);
	assign load = job_valid && job_ready;

	always_comb begin
		idx = '0;
		// Leftmost remaining column wins.
		for (int j = GLYPH_SIZE - 1; j >= 0; j--) begin
			if (rem_q[j]) begin
				idx = GLYPH_IDX_W'(j);
			end
		end
		px = PX_W'(job_q.gx) + PX_W'(idx);
		data_c = '0;
		case (cfg.fmt)
			FMT_1BPP: begin
				boff = BYTE_OFF_W'(px >> 3);
				mask_c = DATA_W'(BIT_MSB >> px[2:0]);
			end
			FMT_4BPP: begin
				boff = BYTE_OFF_W'(px >> 1);
				mask_c = px[0] ? MASK_LO_NIB : MASK_HI_NIB;
			end
			FMT_8BPP: begin
				boff = BYTE_OFF_W'(px);
				mask_c = MASK_BYTE;
			end
			FMT_24BPP: begin
				boff = (BYTE_OFF_W'(px) << 1) + BYTE_OFF_W'(px);
				mask_c = MASK_FULL;
				data_c = cfg.fg;
			end
			default: begin
				boff = BYTE_OFF_W'(px);
				mask_c = MASK_FULL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && last_c) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
			rem_q <= job.pix;
		end else if (emit) begin
			rem_q <= rest;
		end
		if (emit) begin
			addr_q <= job_q.base + ADDR_W'(boff);
			data_q <= data_c;
			mask_q <= mask_c;
			last_q <= last_c;
		end
	end

	assign empty = !ovalid_q;
	assign byte_address = addr_q;
	assign write_data = data_q;
	assign write_mask = mask_q;
	assign last_write = last_q;

	`GRPB_ASSERT_NOW(a_back_busy_has_work, busy_q, rem_q != '0, "generator busy with no ink left")
	`GRPB_ASSERT_NOW(a_back_single_pick, emit, $onehot(pick), "generator picked other than one column")

endmodule

@@ rtl/core/glyph_row_pixel_blitter.sv @@
// Top level of the glyph row pixel blitter: config registers, front end, job queue, write generator.
//
//  channel   dir  handshake          payload
//  glyph in  in   push / full        glyph_row_bits, glyph_x, glyph_y, row_index
//  write out out  empty / pop        byte_address, write_data, write_mask, last_write
//  config    in   cfg_write          cfg_index, cfg_data
//
// A glyph row is accepted every cycle while the job queue has room; rows with no
// visible ink are dropped in the front end and never reach the write side.
// The write generator emits one masked write per cycle while pop keeps the output free,
// one write per visible ink pixel; a row reaches it through the front stages and the job queue.
// arst_n clears all control state and loads the register reset values.
// pop low holds the current write; the queue (four rows) and the front end then fill and full rises.
module glyph_row_pixel_blitter import grpb_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic push,
	output logic full,
	input  logic [GLYPH_SIZE-1:0] glyph_row_bits,
	input  logic [COORD_W-1:0] glyph_x,
	input  logic [COORD_W-1:0] glyph_y,
	input  logic [GLYPH_IDX_W-1:0] row_index,
	output logic empty,
	input  logic pop,
	output logic [ADDR_W-1:0] byte_address,
	output logic [DATA_W-1:0] write_data,
	output logic [DATA_W-1:0] write_mask,
	output logic last_write
);

	grpb_cfg_t cfg_q;
	logic fr_valid, fr_ready, bk_valid, bk_ready;
	grpb_job_t fr_job, bk_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt <= RST_FMT;
			cfg_q.width <= RST_WIDTH;
			cfg_q.height <= RST_HEIGHT;
			cfg_q.fg <= RST_FG;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PIXEL_FORMAT: cfg_q.fmt <= pix_fmt_t'(cfg_data[1:0]);
				CFG_IMAGE_WIDTH: cfg_q.width <= cfg_data[DIM_IN_W-1:0];
				CFG_IMAGE_HEIGHT: cfg_q.height <= cfg_data[DIM_IN_W-1:0];
				CFG_FG_COLOR: cfg_q.fg <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	grpb_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.full(full),
		.glyph_row_bits(glyph_row_bits),
		.glyph_x(glyph_x),
		.glyph_y(glyph_y),
		.row_index(row_index),
		.job_valid(fr_valid),
		.job_ready(fr_ready),
		.job(fr_job)
	);

	grpb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fr_valid),
		.wr_ready(fr_ready),
		.wr_job(fr_job),
		.rd_valid(bk_valid),
		.rd_ready(bk_ready),
		.rd_job(bk_job)
	);

	grpb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_valid(bk_valid),
		.job_ready(bk_ready),
		.job(bk_job),
		.empty(empty),
		.pop(pop),
		.byte_address(byte_address),
		.write_data(write_data),
		.write_mask(write_mask),
		.last_write(last_write)
	);

endmodule

@@ test/glyph_row_write_checker.sv @@
// Checker for the glyph row pixel blitter: predicts framebuffer writes per glyph row and compares.
`timescale 1ns / 100ps

module glyph_row_write_checker import grpb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic push,
	input  logic full,
	input  logic [GLYPH_SIZE-1:0] glyph_row_bits,
	input  logic [COORD_W-1:0] glyph_x,
	input  logic [COORD_W-1:0] glyph_y,
	input  logic [GLYPH_IDX_W-1:0] row_index,
	input  logic empty,
	input  logic pop,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [DATA_W-1:0] write_data,
	input  logic [DATA_W-1:0] write_mask,
	input  logic last_write,
	output int fail_count,
	output int pending_writes
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] mask;
		logic is_last;
	} pixel_write_t;

	pixel_write_t expected_writes[$];
	pixel_write_t want;
	int error_total;

	pix_fmt_t fmt_reg;
	logic [DIM_IN_W-1:0] width_reg;
	logic [DIM_IN_W-1:0] height_reg;
	logic [DATA_W-1:0] fg_reg;

	task automatic report_mismatch(input string what);
		error_total++;
		if (error_total <= 100)
			$display("[%0t] write mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h (addr 0x%0h)",
				name, got, exp_val, want.addr));
	endtask

	// Queue the masked writes one glyph row causes, left to right.
	task automatic queue_row_writes(input logic [GLYPH_SIZE-1:0] ink, input logic [COORD_W-1:0] gx,
			input logic [COORD_W-1:0] gy, input logic [GLYPH_IDX_W-1:0] ri);
		int unsigned w, h, bpp, row_bytes, py, row, px, bitoff;
		pixel_write_t wr, held;
		bit have_held;
		w = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
		h = (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
		case (fmt_reg)
			FMT_1BPP: bpp = 1;
			FMT_4BPP: bpp = 4;
			FMT_8BPP: bpp = 8;
			default: bpp = 24;
		endcase
		row_bytes = ((bpp * w + 31) / 32) * 4;
		py = gy + ri;
		// rows are stored bottom-up; drop rows above or below the image
		if (py == 0 || py > h)
			return;
		row = h - py;
		have_held = 0;
		held = '0;
		for (int j = 0; j < GLYPH_SIZE; j++) begin
			px = gx + j;
			if (ink[GLYPH_SIZE-1-j] && px < w) begin
				bitoff = px * bpp;
				wr.data = '0;
				case (fmt_reg)
					FMT_1BPP: wr.mask = {16'd0, BIT_MSB >> (bitoff % 8)};
					FMT_4BPP: wr.mask = (bitoff % 8 == 0) ? MASK_HI_NIB : MASK_LO_NIB;
					FMT_8BPP: wr.mask = MASK_BYTE;
					default: begin
						wr.data = fg_reg;
						wr.mask = MASK_FULL;
					end
				endcase
				wr.addr = ADDR_W'(row * row_bytes + bitoff / 8);
				wr.is_last = 1'b0;
				if (have_held)
					expected_writes.push_back(held);
				held = wr;
				have_held = 1;
			end
		end
		if (have_held) begin
			held.is_last = 1'b1;
			expected_writes.push_back(held);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_reg = RST_FMT;
			width_reg = RST_WIDTH;
			height_reg = RST_HEIGHT;
			fg_reg = RST_FG;
			expected_writes.delete();
			error_total = 0;
			fail_count <= 0;
			pending_writes <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected write to 0x%0h", byte_address));
				end else begin
					want = expected_writes.pop_front();
					check_field("byte_address", 32'(byte_address), 32'(want.addr));
					check_field("write_data", 32'(write_data), 32'(want.data));
					check_field("write_mask", 32'(write_mask), 32'(want.mask));
					check_field("last_write", 32'(last_write), 32'(want.is_last));
				end
			end
			if (push && !full)
				queue_row_writes(glyph_row_bits, glyph_x, glyph_y, row_index);
			if (cfg_write) begin
				case (cfg_index)
					CFG_PIXEL_FORMAT: fmt_reg = pix_fmt_t'(cfg_data[1:0]);
					CFG_IMAGE_WIDTH: width_reg = cfg_data[DIM_IN_W-1:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_data[DIM_IN_W-1:0];
					CFG_FG_COLOR: fg_reg = cfg_data;
					default: ;
				endcase
			end
			pending_writes <= expected_writes.size();
			fail_count <= error_total;
		end
	end

endmodule

@@ test/glyph_row_pixel_blitter_test.sv @@
// Testbench top for the glyph row pixel blitter: clock, reset, glyph row and config stimulus, verdict.
`timescale 1ns / 100ps

module glyph_row_pixel_blitter_test;
	import grpb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [GLYPH_SIZE-1:0] glyph_row_bits = '0;
	logic [COORD_W-1:0] glyph_x = '0;
	logic [COORD_W-1:0] glyph_y = '0;
	logic [GLYPH_IDX_W-1:0] row_index = '0;
	logic empty;
	logic pop = 1'b0;
	logic [ADDR_W-1:0] byte_address;
	logic [DATA_W-1:0] write_data;
	logic [DATA_W-1:0] write_mask;
	logic last_write;

	int fail_count;
	int pending_writes;
	bit stall_on = 1'b1;
	// effective image size as the block sees it, used to aim glyph rows
	int unsigned img_w = 1920;
	int unsigned img_h = 1080;

	glyph_row_pixel_blitter u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.glyph_row_bits(glyph_row_bits), .glyph_x(glyph_x), .glyph_y(glyph_y),
		.row_index(row_index),
		.empty(empty), .pop(pop),
		.byte_address(byte_address), .write_data(write_data), .write_mask(write_mask),
		.last_write(last_write)
	);

	glyph_row_write_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.glyph_row_bits(glyph_row_bits), .glyph_x(glyph_x), .glyph_y(glyph_y),
		.row_index(row_index),
		.empty(empty), .pop(pop),
		.byte_address(byte_address), .write_data(write_data), .write_mask(write_mask),
		.last_write(last_write),
		.fail_count(fail_count), .pending_writes(pending_writes)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= !stall_on || ($urandom_range(99) >= 35);
	end

	initial begin
		#4_000_000;
		$display("glyph_row_pixel_blitter test failed");
		$finish;
	end

	// Offer one item and hold it until the block takes it.
	task automatic send_row(input logic [GLYPH_SIZE-1:0] ink, input int unsigned x,
			input int unsigned y, input int unsigned ri);
		while (stall_on && $urandom_range(99) < 35) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		glyph_row_bits <= ink;
		glyph_x <= COORD_W'(x);
		glyph_y <= COORD_W'(y);
		row_index <= GLYPH_IDX_W'(ri);
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Hold the sender until every predicted write has come out, then let the pipe empty.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Unused upper bits of the narrow registers carry random junk.
	task automatic configure(input pix_fmt_t fmt, input int unsigned w, input int unsigned h,
			input logic [DATA_W-1:0] fg);
		settle();
		write_reg(CFG_PIXEL_FORMAT, {22'($urandom), fmt});
		write_reg(CFG_IMAGE_WIDTH, {11'($urandom), DIM_IN_W'(w)});
		write_reg(CFG_IMAGE_HEIGHT, {11'($urandom), DIM_IN_W'(h)});
		write_reg(CFG_FG_COLOR, fg);
		cfg_write <= 1'b0;
		img_w = (w % 8192 > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w % 8192;
		img_h = (h % 8192 > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h % 8192;
	endtask

	// Glyph row aimed inside the image, now and then hugging the right edge.
	task automatic send_drawn_row();
		int unsigned mode, x, py, ri;
		logic [GLYPH_SIZE-1:0] ink;
		mode = $urandom_range(9);
		ink = (mode == 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
		if (mode < 7 || img_w <= 16)
			x = $urandom_range(img_w - 1, 0);
		else
			x = $urandom_range(img_w - 1, img_w - 16);
		py = $urandom_range(img_h, 1);
		ri = $urandom_range((py > 15) ? 15 : py, (py > 4095) ? py - 4095 : 0);
		send_row(ink, x, py - ri, ri);
	endtask

	task automatic send_noise_row();
		case ($urandom_range(3))
			0: send_row(16'($urandom), $urandom_range(4095), $urandom_range(4095),
				$urandom_range(15));
			1: send_row(16'h0000, $urandom_range(4095), $urandom_range(4095), $urandom_range(15));
			2: begin
				if (img_h + 1 > 4095)
					send_row(16'($urandom), $urandom_range(4095), 4095, 15);
				else
					send_row(16'($urandom), $urandom_range(4095), img_h + 1, 0);
			end
			default: send_row(16'($urandom), $urandom_range(4095), 0, 0);
		endcase
	endtask

	task automatic run_phase(input int drawn, input int noise);
		while (drawn + noise > 0) begin
			if (img_w == 0 || img_h == 0 || drawn == 0
					|| (noise > 0 && $urandom_range(drawn + noise - 1) < noise)) begin
				send_noise_row();
				noise = noise > 0 ? noise - 1 : 0;
				if (noise == 0)
					drawn = 0;
			end else begin
				send_drawn_row();
				drawn--;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 24 bpp, 1920 x 1080, black ink
		send_row(16'hFFFF, 0, 1, 0);
		send_row(16'h8000, 0, 1080, 0);
		send_row(16'h0001, 1904, 0, 1);
		send_row(16'hFFFF, 1910, 500, 7);
		send_row(16'hFFFF, 1920, 10, 0);
		send_row(16'hFFFF, 4095, 4095, 15);
		send_row(16'hFFFF, 0, 0, 0);
		send_row(16'hFFFF, 0, 1081, 0);
		send_row(16'hFFFF, 0, 1066, 15);
		send_row(16'hFFFF, 0, 1065, 15);
		send_row(16'h0000, 100, 100, 3);
		send_row(16'hAAAA, 2047, 2047, 8);
		send_row(16'h5555, 1024, 512, 4);
		send_row(16'h8001, 0, 0, 15);
		send_row(16'h7FFE, 1905, 1079, 1);

		// no random idling on push or pop for the whole of this phase
		configure(FMT_24BPP, 4096, 4096, 24'hFFFFFF);
		stall_on <= 1'b0;
		run_phase(60, 15);
		configure(FMT_1BPP, 1, 1, 24'h000000);
		stall_on <= 1'b1;
		run_phase(20, 8);
		configure(FMT_4BPP, 8191, 8191, 24'h5A3C96);
		run_phase(25, 8);
		settle();
		run_phase(25, 8);
		configure(FMT_8BPP, 0, 200, 24'hC33C0F);
		run_phase(0, 10);
		configure(FMT_1BPP, 333, 0, 24'h0F0F0F);
		run_phase(0, 10);
		configure(FMT_4BPP, 17, 9, 24'hA5A5A5);
		run_phase(30, 10);
		repeat (2) begin
			configure(pix_fmt_t'($urandom_range(3)),
				($urandom_range(3) == 0) ? $urandom_range(8191, 4096) : $urandom_range(700, 1),
				$urandom_range(4096, 1), 24'($urandom));
			run_phase(30, 10);
		end
		settle();

		if (fail_count == 0 && pending_writes == 0)
			$display("glyph_row_pixel_blitter test passed");
		else
			$display("glyph_row_pixel_blitter test failed");
		$finish;
	end

endmodule
